>>> rtl/core/mcvp_pkg.sv
// Shared types, constants and lookup functions of the marching-cubes polygonizer.
// Holds the standard triangle table and the edge geometry; has no dependencies.
`timescale 1ns / 1ps

package mcvp_pkg;

  localparam int unsigned NUM_EDGES = 12;
  localparam logic [3:0]  LAST_EDGE = 4'd11;
  localparam logic [3:0]  END_MARK  = 4'hF;
  localparam logic [7:0]  CUBE_ALL  = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DIV,
    ST_RD,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic [7:0]         voxel_x;
    logic [7:0]         voxel_y;
    logic [7:0]         voxel_z;
    logic signed [15:0] corner_density_0;
    logic signed [15:0] corner_density_1;
    logic signed [15:0] corner_density_2;
    logic signed [15:0] corner_density_3;
    logic signed [15:0] corner_density_4;
    logic signed [15:0] corner_density_5;
    logic signed [15:0] corner_density_6;
    logic signed [15:0] corner_density_7;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] vertex_x;
    logic [15:0] vertex_y;
    logic [15:0] vertex_z;
    logic [31:0] vertex_number;
    logic        last_of_voxel;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [47:0] data;
  } scr_wr_t;

  // Edge endpoints as corner numbers x + 2y + 4z.
  localparam logic [2:0] EDGE_LO [NUM_EDGES] =
    '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6, 3'd0, 3'd1, 3'd3, 3'd2};
  localparam logic [2:0] EDGE_HI [NUM_EDGES] =
    '{3'd1, 3'd3, 3'd2, 3'd0, 3'd5, 3'd7, 3'd6, 3'd4, 3'd4, 3'd5, 3'd7, 3'd6};
  // Cube-index vertex to input corner.
  localparam logic [2:0] VERT_CORNER [8] =
    '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6};

  // Triangle rows, first entry in the top nibble, padded with the end mark.
  localparam logic [63:0] TRI_TABLE [256] = '{
    64'hFFFFFFFFFFFFFFFF, 64'h083FFFFFFFFFFFFF, 64'h019FFFFFFFFFFFFF, 64'h183981FFFFFFFFFF,
    64'h12AFFFFFFFFFFFFF, 64'h08312AFFFFFFFFFF, 64'h92A029FFFFFFFFFF, 64'h2832A8A98FFFFFFF,
    64'h3B2FFFFFFFFFFFFF, 64'h0B28B0FFFFFFFFFF, 64'h19023BFFFFFFFFFF, 64'h1B219B98BFFFFFFF,
    64'h3A1BA3FFFFFFFFFF, 64'h0A108A8BAFFFFFFF, 64'h3903B9BA9FFFFFFF, 64'h98AA8BFFFFFFFFFF,
    64'h478FFFFFFFFFFFFF, 64'h430734FFFFFFFFFF, 64'h019847FFFFFFFFFF, 64'h419471731FFFFFFF,
    64'h12A847FFFFFFFFFF, 64'h34730412AFFFFFFF, 64'h92A902847FFFFFFF, 64'h2A9297273794FFFF,
    64'h8473B2FFFFFFFFFF, 64'hB47B24204FFFFFFF, 64'h90184723BFFFFFFF, 64'h47B94B9B2921FFFF,
    64'h3A13BA784FFFFFFF, 64'h1BA14B1047B4FFFF, 64'h47890B9BAB03FFFF, 64'h47B4B99BAFFFFFFF,
    64'h954FFFFFFFFFFFFF, 64'h954083FFFFFFFFFF, 64'h054150FFFFFFFFFF, 64'h854835315FFFFFFF,
    64'h12A954FFFFFFFFFF, 64'h30812A495FFFFFFF, 64'h52A542402FFFFFFF, 64'h2A5325354348FFFF,
    64'h95423BFFFFFFFFFF, 64'h0B208B495FFFFFFF, 64'h05401523BFFFFFFF, 64'h21525828B485FFFF,
    64'hA3BA13954FFFFFFF, 64'h4950818A18BAFFFF, 64'h54050B5BAB03FFFF, 64'h54858AA8BFFFFFFF,
    64'h978579FFFFFFFFFF, 64'h930953573FFFFFFF, 64'h078017157FFFFFFF, 64'h153357FFFFFFFFFF,
    64'h978957A12FFFFFFF, 64'hA12950530573FFFF, 64'h802825857A52FFFF, 64'h2A5253357FFFFFFF,
    64'h7957893B2FFFFFFF, 64'h95797292027BFFFF, 64'h23B018178157FFFF, 64'hB21B17715FFFFFFF,
    64'h958857A13A3BFFFF, 64'h5705097B010ABA0F, 64'hBA0B03A50807570F, 64'hBA57B5FFFFFFFFFF,
    64'hA65FFFFFFFFFFFFF, 64'h0835A6FFFFFFFFFF, 64'h9015A6FFFFFFFFFF, 64'h1831985A6FFFFFFF,
    64'h165261FFFFFFFFFF, 64'h165126308FFFFFFF, 64'h965906026FFFFFFF, 64'h598582526328FFFF,
    64'h23BA65FFFFFFFFFF, 64'hB08B20A65FFFFFFF, 64'h01923B5A6FFFFFFF, 64'h5A61929B298BFFFF,
    64'h63B653513FFFFFFF, 64'h08B0B50515B6FFFF, 64'h3B6036065059FFFF, 64'h65969BB98FFFFFFF,
    64'h5A6478FFFFFFFFFF, 64'h43047365AFFFFFFF, 64'h1905A6847FFFFFFF, 64'hA65197173794FFFF,
    64'h612651478FFFFFFF, 64'h125526304347FFFF, 64'h847905065026FFFF, 64'h739794329596269F,
    64'h3B2784A65FFFFFFF, 64'h5A647242027BFFFF, 64'h01947823B5A6FFFF, 64'h9219B294B7B45A6F,
    64'h8473B53515B6FFFF, 64'h51B5B610B7B404BF, 64'h059065036B63847F, 64'h65969B4797B9FFFF,
    64'hA4964AFFFFFFFFFF, 64'h4A649A083FFFFFFF, 64'hA01A60640FFFFFFF, 64'h83181686461AFFFF,
    64'h149124264FFFFFFF, 64'h308129249264FFFF, 64'h024426FFFFFFFFFF, 64'h832824426FFFFFFF,
    64'hA49A64B23FFFFFFF, 64'h08228B49A4A6FFFF, 64'h3B201606461AFFFF, 64'h64161A48121B8B1F,
    64'h964936913B63FFFF, 64'h8B1810B61914641F, 64'h3B6360064FFFFFFF, 64'h648B68FFFFFFFFFF,
    64'h7A678A89AFFFFFFF, 64'h0730A709A67AFFFF, 64'hA671A7178180FFFF, 64'hA67A71173FFFFFFF,
    64'h126168189867FFFF, 64'h269291679093739F, 64'h780706602FFFFFFF, 64'h732672FFFFFFFFFF,
    64'h23BA68A89867FFFF, 64'h20727B09767A9A7F, 64'h1801781A767A23BF, 64'hB21B17A61671FFFF,
    64'h896867916B63136F, 64'h091B67FFFFFFFFFF, 64'h7807063B0B60FFFF, 64'h7B6FFFFFFFFFFFFF,
    64'h76BFFFFFFFFFFFFF, 64'h308B76FFFFFFFFFF, 64'h019B76FFFFFFFFFF, 64'h819831B76FFFFFFF,
    64'hA126B7FFFFFFFFFF, 64'h12A3086B7FFFFFFF, 64'h2902A96B7FFFFFFF, 64'h6B72A3A83A98FFFF,
    64'h723627FFFFFFFFFF, 64'h708760620FFFFFFF, 64'h276237019FFFFFFF, 64'h162186198876FFFF,
    64'hA76A17137FFFFFFF, 64'hA7617A187108FFFF, 64'h03707A0A96A7FFFF, 64'h76A7A88A9FFFFFFF,
    64'h684B86FFFFFFFFFF, 64'h36B306046FFFFFFF, 64'h86B846901FFFFFFF, 64'h946963931B36FFFF,
    64'h6846B82A1FFFFFFF, 64'h12A30B06B046FFFF, 64'h4B846B0292A9FFFF, 64'hA93A32943B36463F,
    64'h823842462FFFFFFF, 64'h042462FFFFFFFFFF, 64'h190234246438FFFF, 64'h194142246FFFFFFF,
    64'h8138618466A1FFFF, 64'hA10A06604FFFFFFF, 64'h4634386A3039A93F, 64'hA946A4FFFFFFFFFF,
    64'h49576BFFFFFFFFFF, 64'h083495B76FFFFFFF, 64'h50154076BFFFFFFF, 64'hB76834354315FFFF,
    64'h954A1276BFFFFFFF, 64'h6B712A083495FFFF, 64'h76B54A42A402FFFF, 64'h348354325A52B76F,
    64'h723762549FFFFFFF, 64'h954086062687FFFF, 64'h362376150540FFFF, 64'h628687218485158F,
    64'h954A16176137FFFF, 64'h16A176107870954F, 64'h40A4A503A6A737AF, 64'h76A7A854A48AFFFF,
    64'h6956B9B89FFFFFFF, 64'h36B063056095FFFF, 64'h0B805B01556BFFFF, 64'h6B3635531FFFFFFF,
    64'h12A95B9B8B56FFFF, 64'h0B306B09656912AF, 64'hB85B56805A52025F, 64'h6B36352A3A53FFFF,
    64'h589528562382FFFF, 64'h956960062FFFFFFF, 64'h158180568382628F, 64'h156216FFFFFFFFFF,
    64'h13616A386569896F, 64'hA10A06950560FFFF, 64'h03856AFFFFFFFFFF, 64'hA56FFFFFFFFFFFFF,
    64'hB5A75BFFFFFFFFFF, 64'hB5AB75830FFFFFFF, 64'h5B75AB190FFFFFFF, 64'hA75AB7981831FFFF,
    64'hB12B71751FFFFFFF, 64'h08312717572BFFFF, 64'h9759279022B7FFFF, 64'h75272B592328982F,
    64'h25A235375FFFFFFF, 64'h820852875A25FFFF, 64'h9015A35373A2FFFF, 64'h982921872A25752F,
    64'h135375FFFFFFFFFF, 64'h087071175FFFFFFF, 64'h903935537FFFFFFF, 64'h987597FFFFFFFFFF,
    64'h5845A8AB8FFFFFFF, 64'h5045B05ABB30FFFF, 64'h01984A8ABA45FFFF, 64'hAB4A45B34941314F,
    64'h2512852B8458FFFF, 64'h04B0B345B2B151BF, 64'h0250592B5458B85F, 64'h9452B3FFFFFFFFFF,
    64'h25A352345384FFFF, 64'h5A2524420FFFFFFF, 64'h3A235A385458019F, 64'h5A2524192942FFFF,
    64'h845853351FFFFFFF, 64'h045105FFFFFFFFFF, 64'h845853905035FFFF, 64'h945FFFFFFFFFFFFF,
    64'h4B749B9ABFFFFFFF, 64'h0834979B79ABFFFF, 64'h1AB1B414074BFFFF, 64'h3143481A474BAB4F,
    64'h4B79B492B912FFFF, 64'h9749B791B2B1083F, 64'hB74B42240FFFFFFF, 64'hB74B42834324FFFF,
    64'h29A279237749FFFF, 64'h9A7974A27870207F, 64'h37A3A274A1A040AF, 64'h1A2874FFFFFFFFFF,
    64'h491417713FFFFFFF, 64'h491417081871FFFF, 64'h403743FFFFFFFFFF, 64'h487FFFFFFFFFFFFF,
    64'h9A8AB8FFFFFFFFFF, 64'h30939BB9AFFFFFFF, 64'h01A0A88ABFFFFFFF, 64'h31AB3AFFFFFFFFFF,
    64'h12B1B99B8FFFFFFF, 64'h30939B1292B9FFFF, 64'h02B80BFFFFFFFFFF, 64'h32BFFFFFFFFFFFFF,
    64'h23828AA89FFFFFFF, 64'h9A2092FFFFFFFFFF, 64'h23828A0181A8FFFF, 64'h1A2FFFFFFFFFFFFF,
    64'h138918FFFFFFFFFF, 64'h091FFFFFFFFFFFFF, 64'h038FFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF
  };

  function automatic logic signed [15:0] pick_dens(in_beat_t b, logic [2:0] c);
    logic signed [15:0] d;
    case (c)
      3'd0: d = b.corner_density_0;
      3'd1: d = b.corner_density_1;
      3'd2: d = b.corner_density_2;
      3'd3: d = b.corner_density_3;
      3'd4: d = b.corner_density_4;
      3'd5: d = b.corner_density_5;
      3'd6: d = b.corner_density_6;
      default: d = b.corner_density_7;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] cube_index(in_beat_t b, logic signed [15:0] iso);
    logic [7:0] c;
    for (int v = 0; v < 8; v++) begin
      c[v] = (pick_dens(b, VERT_CORNER[v]) >= iso);
    end
    return c;
  endfunction

  // An edge is cut when its two cube vertices fall on opposite sides.
  function automatic logic [NUM_EDGES-1:0] edge_mask(logic [7:0] cube);
    logic [NUM_EDGES-1:0] m;
    int unsigned a;
    int unsigned b;
    for (int unsigned e = 0; e < NUM_EDGES; e++) begin
      a = (e < 8) ? (e & 7) : (e - 8);
      b = (e < 8) ? ((e & 4) | ((e + 1) & 3)) : (e - 4);
      m[e] = cube[a[2:0]] ^ cube[b[2:0]];
    end
    return m;
  endfunction

  function automatic logic [3:0] tri_edge(logic [63:0] row, logic [3:0] i);
    return row[(4'd15 - i) * 4 +: 4];
  endfunction

  function automatic logic [3:0] tri_count(logic [63:0] row);
    logic [3:0] n;
    logic       found;
    n     = 4'd15;
    found = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!found && row[(15 - i) * 4 +: 4] == END_MARK) begin
        n     = 4'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/core/marching_cubes_voxel_polygonizer.sv
// Top level of the marching-cubes polygonizer: control sequencer, output register.
// Depends on mcvp_pkg, mcvp_divider and mcvp_scratch.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Beat
// ---------+-----------+------------------------+--------------------------------
// in       | input     | in_valid_i/in_ready_o  | in_beat_t: one voxel
// out      | output    | out_valid_o/out_ready_i| out_beat_t: one triangle vertex
// cfg      | input     | cfg_we_i (no wait)     | iso_level, signed Q8.8
//
// A voxel is accepted, then each uncut edge is stepped over and each cut edge goes
// through the shared bit-serial divider; each vertex beat is then read (ST_RD, then
// ST_LOAD) through the single read port of the edge vertex memory. Voxels outside
// the grid and fully inside or outside cubes only take the accept step.
// Reset clears the state machine, the vertex counter, iso_level and the output flag.
// A stalled output holds its beat; the block takes a new voxel once the last beat of
// the previous one sits in the output register.

module marching_cubes_voxel_polygonizer import mcvp_pkg::*; #(
  parameter int unsigned GRID_SIZE = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_beat_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_beat_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_wdata_i
);

  localparam logic [8:0] VOX_MAX = 9'(GRID_SIZE - 2);

  state_e             state_q, state_d;
  logic [3:0]         e_q, e_d;
  logic [3:0]         i_q, i_d;
  logic [7:0]         cube_q, cube_d;
  logic [3:0]         count_q, count_d;
  logic [31:0]        vtx_cnt_q, vtx_cnt_d;
  logic signed [15:0] iso_q;
  in_beat_t           in_q;
  logic               in_load;
  out_beat_t          out_q;
  logic               out_valid_q, out_valid_d;
  logic               out_load;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [FRAC_BITS:0] frac;
  scr_wr_t            scr_wr;
  logic               rd_en;
  logic [3:0]         rd_addr;
  logic [47:0]        rd_data;

  logic [7:0]           cube_in;
  logic                 in_range;
  logic [NUM_EDGES-1:0] cut;
  logic [2:0]           lo, hi;
  logic signed [15:0]   d_lo, d_hi;
  logic signed [16:0]   num_s, den_s, num_n, den_n;
  logic [15:0]          div_num, div_den;
  logic [15:0]          pos [3];
  logic [8:0]           base;

  mcvp_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp),
    .frac_o(frac)
  );

  mcvp_scratch u_scr (
    .clk_i    (clk_i),
    .wr_i     (scr_wr),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Corner classification of the arriving voxel.
  assign cube_in  = cube_index(in_data_i, iso_q);
  assign in_range = ({1'b0, in_data_i.voxel_x} <= VOX_MAX) &&
                    ({1'b0, in_data_i.voxel_y} <= VOX_MAX) &&
                    ({1'b0, in_data_i.voxel_z} <= VOX_MAX);
  assign cut      = edge_mask(cube_q);

  // Divider operands for the current edge: t = (iso - dL) / (dH - dL), clamped
  // to [0,1]. A degenerate edge gets zero over one, which rounds to zero.
  always_comb begin
    lo    = EDGE_LO[e_q];
    hi    = EDGE_HI[e_q];
    d_lo  = pick_dens(in_q, lo);
    d_hi  = pick_dens(in_q, hi);
    num_s = {iso_q[15], iso_q} - {d_lo[15], d_lo};
    den_s = {d_hi[15], d_hi} - {d_lo[15], d_lo};
    if (den_s < 0) begin
      num_n = -num_s;
      den_n = -den_s;
    end else begin
      num_n = num_s;
      den_n = den_s;
    end
    if (den_n == '0 || num_n <= 0) begin
      div_num = 16'd0;
      div_den = 16'd1;
    end else if (num_n > den_n) begin
      div_num = den_n[15:0];
      div_den = den_n[15:0];
    end else begin
      div_num = num_n[15:0];
      div_den = den_n[15:0];
    end
  end

  // Vertex position: corner of the edge's EDGE_LO endpoint plus the fraction along the
  // edge's own axis, all modulo 2^16.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      case (a)
        0:       base = {1'b0, in_q.voxel_x} + 9'(lo[0]);
        1:       base = {1'b0, in_q.voxel_y} + 9'(lo[1]);
        default: base = {1'b0, in_q.voxel_z} + 9'(lo[2]);
      endcase
      pos[a] = 16'(32'(base) << FRAC_BITS);
      if (lo[a] ^ hi[a]) begin
        pos[a] = pos[a] + 16'(frac);
      end
    end
  end

  assign rd_addr = tri_edge(TRI_TABLE[cube_q], i_q);

  // Sequencer: classify, walk every edge up to LAST_EDGE, then replay the triangle row.
  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    i_d         = i_q;
    cube_d      = cube_q;
    count_d     = count_q;
    vtx_cnt_d   = vtx_cnt_q;
    in_load     = 1'b0;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    div_req     = '{start: 1'b0, num: div_num, den: div_den};
    scr_wr      = '{en: 1'b0, addr: e_q, data: {pos[0], pos[1], pos[2]}};
    in_ready_o  = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_load = 1'b1;
          if (in_range && cube_in != '0 && cube_in != CUBE_ALL) begin
            cube_d  = cube_in;
            count_d = tri_count(TRI_TABLE[cube_in]);
            e_d     = '0;
            state_d = ST_EDGE;
          end
        end
      end
      ST_EDGE: begin
        if (cut[e_q]) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else if (e_q == LAST_EDGE) begin
          i_d     = '0;
          state_d = (count_q == '0) ? ST_IDLE : ST_RD;
        end else begin
          e_d = e_q + 4'd1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          scr_wr.en = 1'b1;
          if (e_q == LAST_EDGE) begin
            i_d     = '0;
            state_d = (count_q == '0) ? ST_IDLE : ST_RD;
          end else begin
            e_d     = e_q + 4'd1;
            state_d = ST_EDGE;
          end
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load  = 1'b1;
          vtx_cnt_d = vtx_cnt_q + 32'd1;
          if (i_q + 4'd1 == count_q) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 4'd1;
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      e_q         <= '0;
      i_q         <= '0;
      cube_q      <= '0;
      count_q     <= '0;
      vtx_cnt_q   <= '0;
      iso_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      e_q         <= e_d;
      i_q         <= i_d;
      cube_q      <= cube_d;
      count_q     <= count_d;
      vtx_cnt_q   <= vtx_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        iso_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q.vertex_x      <= rd_data[47:32];
      out_q.vertex_y      <= rd_data[31:16];
      out_q.vertex_z      <= rd_data[15:0];
      out_q.vertex_number <= vtx_cnt_q;
      out_q.last_of_voxel <= (i_q + 4'd1 == count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // Edge vertices are only written when a division has just finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scr_wr.en |-> (state_q == ST_DIV) && div_rsp.done)
    else $error("edge vertex written outside a finished division");

  // Every loaded beat advances the running vertex number by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (vtx_cnt_q == $past(vtx_cnt_q) + 32'd1) && out_valid_o)
    else $error("vertex counter did not follow the loaded beat");

  // A new voxel is never taken while the divider still works on an edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("voxel accepted with the divider busy");
`endif

endmodule

>>> rtl/core/mcvp_divider.sv
// Bit-serial restoring divider giving the rounded edge fraction of one cut edge.
// Depends on mcvp_pkg for the request and response structs.
`timescale 1ns / 1ps

module mcvp_divider import mcvp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output div_rsp_t           rsp_o,
  output logic [FRAC_BITS:0] frac_o
);

  // One integer bit plus FRAC_BITS+1 fraction bits, then round by halving.
  localparam int unsigned STEPS = FRAC_BITS + 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 first_q, first_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [15:0]          rem_q, rem_d;
  logic [15:0]          den_q, den_d;
  logic [FRAC_BITS+1:0] quo_q, quo_d;
  logic [16:0]          trial;
  logic                 ge;
  logic [16:0]          diff;
  logic [FRAC_BITS+1:0] quo_inc;

  always_comb begin
    trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};

    busy_d  = busy_q;
    done_d  = 1'b0;
    first_d = first_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CW'(STEPS);
      rem_d   = req_i.num;
      den_d   = req_i.den;
      quo_d   = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rem_d   = ge ? diff[15:0] : trial[15:0];
      quo_d   = {quo_q[FRAC_BITS:0], ge};
      cnt_d   = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_inc    = quo_q + (FRAC_BITS+2)'(1);
  assign frac_o     = quo_inc[FRAC_BITS+1:1];
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule

>>> rtl/core/mcvp_scratch.sv
// Twelve-entry edge vertex memory, one write port and one registered read port.
// Depends on mcvp_pkg for the write port struct.
`timescale 1ns / 1ps

module mcvp_scratch import mcvp_pkg::*; (
  input  logic        clk_i,
  input  scr_wr_t     wr_i,
  input  logic        rd_en_i,
  input  logic [3:0]  rd_addr_i,
  output logic [47:0] rd_data_o
);

  logic [47:0] mem_q [NUM_EDGES];
  logic [47:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
